### rtl/core/pdf_text_object_extractor_macros.svh
// Assertion macros for the text object extractor.
// Expects clk and rst_n in the scope of the module that includes it.
`ifndef PDF_TEXT_OBJECT_EXTRACTOR_MACROS_SVH
`define PDF_TEXT_OBJECT_EXTRACTOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pte_pkg.sv
// Shared types, character codes and helpers for the text object extractor.
// No dependencies; used by pte_num_parse and pdf_text_object_extractor.
package pte_pkg;

  localparam int BYTE_W            = 8;
  localparam int THR_W             = 16;
  localparam int IP_W              = THR_W + 1;
  localparam int CFG_IDX_W         = 1;
  localparam int HISTORY_DEPTH_DEF = 15;
  localparam int SIG_DIGITS        = 5;
  localparam int GRP_MAX           = 3;
  localparam int GRP_CNT_W         = 2;

  // Integer parts at or above this value all compare alike against 16-bit thresholds.
  localparam logic [IP_W-1:0] IP_SAT  = IP_W'(17'h10000);
  localparam logic [IP_W-1:0] IP_ONE  = IP_W'(1);
  localparam logic [IP_W-1:0] IP_ZERO = '0;

  localparam logic [THR_W-1:0] SPACE_GAP_RST = THR_W'(100);
  localparam logic [THR_W-1:0] TAB_GAP_RST   = THR_W'(1000);

  localparam logic [IP_W-1:0] DEC_WEIGHT [SIG_DIGITS] = '{
    IP_W'(1), IP_W'(10), IP_W'(100), IP_W'(1000), IP_W'(10000)
  };

  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2e;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h42;
  localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
  localparam logic [BYTE_W-1:0] CH_E      = 8'h45;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACE_GAP = 1'b0,
    CFG_TAB_GAP   = 1'b1
  } cfg_idx_t;

  // Decimal number found before a token or an opening paren.
  typedef struct packed {
    logic            ok;
    logic            fnz;
    logic [IP_W-1:0] ip;
  } num_t;

  function automatic logic is_sep(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_print(input logic [BYTE_W-1:0] b);
    return (b >= CH_SPACE) && (b != CH_DEL) && (b != CH_FF);
  endfunction

endpackage

### rtl/core/pte_num_parse.sv
// Parallel decimal number reader over the history window, ending at position POS.
// Depends on pte_pkg; instantiated twice by pdf_text_object_extractor.
module pte_num_parse
  import pte_pkg::*;
#(
  parameter int DEPTH = HISTORY_DEPTH_DEF,
  parameter int POS   = HISTORY_DEPTH_DEF - 1
) (
  input  logic [DEPTH-1:0][BYTE_W-1:0] hist_i,
  output num_t                         num_o
);

  localparam int W = POS + 1;

  logic [W-1:0]                sp_v, dig_v, dot_v, nz_v;
  logic [W-1:0]                tail_sp, cont_v, in_run, dot_run;
  logic [W-1:0]                int_dig, frac_dig, top_v, sat_v;
  logic [W:0]                  int_ext;
  logic [W+SIG_DIGITS-2:0]     top_ext;
  logic [W-1:0][3:0]           dv;
  logic [SIG_DIGITS-1:0][3:0]  dsel;
  logic [IP_W-1:0]             val;

  always_comb begin
    logic [W-1:0] below;
    logic         acc;
    // Position 0 never takes part in a number.
    for (int j = 0; j < W; j++) begin
      if (j == 0) begin
        sp_v[j]  = 1'b0;
        dig_v[j] = 1'b0;
        dot_v[j] = 1'b0;
      end else begin
        sp_v[j]  = (hist_i[j] == CH_SPACE);
        dig_v[j] = is_digit(hist_i[j]);
        dot_v[j] = (hist_i[j] == CH_DOT);
      end
      dv[j]   = dig_v[j] ? hist_i[j][3:0] : 4'd0;
      nz_v[j] = dig_v[j] && (hist_i[j] != CH_ZERO);
    end

    for (int j = 0; j < W; j++) begin
      acc = 1'b1;
      for (int k = j; k < W; k++) acc = acc & sp_v[k];
      tail_sp[j] = acc;
      // A position may lie above the run only as a digit, a dot or trailing spaces.
      cont_v[j] = dig_v[j] || dot_v[j] || tail_sp[j];
    end

    for (int j = 0; j < W; j++) begin
      acc = dig_v[j] || dot_v[j];
      for (int k = j + 1; k < W; k++) acc = acc & cont_v[k];
      in_run[j] = acc;
    end
    dot_run = in_run & dot_v;

    for (int j = 0; j < W; j++) begin
      acc = in_run[j] && dig_v[j];
      for (int k = 0; k < j; k++) acc = acc & (!in_run[k] || dig_v[k]);
      int_dig[j] = acc;
      // A fraction digit has exactly one dot of the run below it.
      below = dot_run & ((W'(1) << j) - W'(1));
      frac_dig[j] = in_run[j] && dig_v[j] && (below != '0) &&
                    ((below & (below - W'(1))) == '0);
    end

    int_ext = {1'b0, int_dig};
    for (int j = 0; j < W; j++) top_v[j] = int_dig[j] && !int_ext[j+1];

    top_ext = {{(SIG_DIGITS-1){1'b0}}, top_v};
    for (int j = 0; j < W; j++) begin
      sat_v[j] = int_dig[j] && nz_v[j] && !(|top_ext[j +: SIG_DIGITS]);
    end

    for (int k = 0; k < SIG_DIGITS; k++) begin
      dsel[k] = 4'd0;
      for (int j = k; j < W; j++) begin
        if (top_v[j] && int_dig[j-k]) dsel[k] = dsel[k] | dv[j-k];
      end
    end

    val = '0;
    for (int k = 0; k < SIG_DIGITS; k++) begin
      val = val + IP_W'(dsel[k]) * DEC_WEIGHT[k];
    end

    num_o.ok  = (|int_dig) || (|frac_dig);
    num_o.fnz = |(frac_dig & nz_v);
    num_o.ip  = ((|sat_v) || (val >= IP_SAT)) ? IP_SAT : val;
  end

endmodule

### rtl/core/pdf_text_object_extractor.sv
// Top level of the text object extractor: history window, item decode and result buffer.
// Depends on pte_pkg, pte_num_parse and pdf_text_object_extractor_macros.svh.
//
//   channel | direction | tdata           | tlast          | tuser
//   in_     | slave     | in_byte [7:0]   | last_in_stream | -
//   out_    | master    | out_char [7:0]  | last_of_run    | -
//   cfg_    | write     | cfg_wdata: threshold, cfg_index selects the register
//
// One byte is accepted per cycle unless the input stage stalls; a result is registered
// in the input stage, then in the result buffer. A byte giving n characters holds the
// buffer until all n are taken; a following byte with results waits in the input stage.
// The number reader and token match run on the history before the input stage.
// Reset is synchronous: history to spaces, flags clear, thresholds 100 and 1000.
`include "pdf_text_object_extractor_macros.svh"

module pdf_text_object_extractor
  import pte_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] in_byte
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // [7:0] out_char
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_wdata
);

  localparam int D = HISTORY_DEPTH;
  localparam logic [D-1:0][BYTE_W-1:0] HIST_RESET = {D{CH_SPACE}};

  logic [D-1:0][BYTE_W-1:0] hist_r;
  logic                     s1_v_r;
  logic [BYTE_W-1:0]        s1_byte_r;
  logic                     s1_last_r, s1_td_r, s1_et_r, s1_bt_r;
  num_t                     s1_num_td_r, s1_num_pa_r;
  logic                     tobj_r, str_r, esc_r;
  logic                     tobj_nxt, str_nxt, esc_nxt;
  logic [THR_W-1:0]         spc_thr_r, tab_thr_r;
  logic [BYTE_W-1:0]        grp_chr_r [GRP_MAX];
  logic [GRP_CNT_W-1:0]     grp_cnt_r;

  num_t                     num_td, num_pa;
  logic                     in_acc, td_hit, et_hit, bt_hit;
  logic                     s1_adv, grp_free, pop;
  logic [BYTE_W-1:0]        chr [GRP_MAX];
  logic [GRP_CNT_W-1:0]     n_new;

  pte_num_parse #(.DEPTH(D), .POS(D - 5)) u_num_td (.hist_i(hist_r), .num_o(num_td));
  pte_num_parse #(.DEPTH(D), .POS(D - 1)) u_num_pa (.hist_i(hist_r), .num_o(num_pa));

  assign in_acc = in_tvalid && in_tready;
  assign td_hit = (hist_r[D-3] == CH_T) && (hist_r[D-2] == CH_D) &&
                  is_sep(hist_r[D-1]) && is_sep(hist_r[D-4]);
  assign et_hit = (hist_r[D-3] == CH_E) && (hist_r[D-2] == CH_T) &&
                  is_sep(hist_r[D-1]) && is_sep(hist_r[D-4]);
  // BT is looked for in the window as it stands after this byte has shifted in.
  assign bt_hit = (hist_r[D-2] == CH_B) && (hist_r[D-1] == CH_T) &&
                  is_sep(in_tdata) && is_sep(hist_r[D-3]);

  assign pop        = out_tvalid && out_tready;
  assign grp_free   = (grp_cnt_r == '0) || ((grp_cnt_r == GRP_CNT_W'(1)) && out_tready);
  assign s1_adv     = s1_v_r && ((n_new == '0) || grp_free);
  assign in_tready  = !s1_v_r || s1_adv;
  assign out_tvalid = (grp_cnt_r != '0);
  assign out_tdata  = grp_chr_r[0];
  assign out_tlast  = (grp_cnt_r == GRP_CNT_W'(1));

  // Decode of the item in the input stage against the text state.
  always_comb begin
    logic             td_act, et_act, td_crlf, td_tab;
    logic             b_v;
    logic [BYTE_W-1:0] b_ch;
    td_act   = tobj_r && !str_r && s1_td_r;
    et_act   = tobj_r && !str_r && s1_et_r;
    td_crlf  = td_act && s1_num_td_r.ok &&
               ((s1_num_td_r.ip > IP_ONE) || ((s1_num_td_r.ip == IP_ONE) && s1_num_td_r.fnz));
    td_tab   = td_act && (!s1_num_td_r.ok || (s1_num_td_r.ip == IP_ZERO));
    b_v      = 1'b0;
    b_ch     = s1_byte_r;
    tobj_nxt = tobj_r;
    str_nxt  = str_r;
    esc_nxt  = esc_r;

    priority if (!tobj_r) begin
    end else if (et_act) begin
      tobj_nxt = 1'b0;
    end else if ((s1_byte_r == CH_LPAREN) && !str_r && !esc_r) begin
      str_nxt = 1'b1;
      if (s1_num_pa_r.ok && (s1_num_pa_r.ip != IP_ZERO)) begin
        if (s1_num_pa_r.ip > IP_W'(tab_thr_r)) begin
          b_v  = 1'b1;
          b_ch = CH_TAB;
        end else if (s1_num_pa_r.ip > IP_W'(spc_thr_r)) begin
          b_v  = 1'b1;
          b_ch = CH_SPACE;
        end
      end
    end else if ((s1_byte_r == CH_RPAREN) && str_r && !esc_r) begin
      str_nxt  = 1'b0;
    end else if (str_r) begin
      if ((s1_byte_r == CH_BSLASH) && !esc_r) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        b_v     = is_print(s1_byte_r);
      end
    end else begin
    end

    if (!tobj_nxt && s1_bt_r) tobj_nxt = 1'b1;
    if (s1_last_r) begin
      tobj_nxt = 1'b0;
      str_nxt  = 1'b0;
      esc_nxt  = 1'b0;
    end

    // TD and ET exclude each other, so at most three characters result.
    chr[0] = b_ch;
    chr[1] = b_ch;
    chr[2] = b_ch;
    priority if (et_act) begin
      chr[0] = CH_CR;
      chr[1] = CH_LF;
      n_new  = GRP_CNT_W'(2);
    end else if (td_crlf) begin
      chr[0] = CH_CR;
      chr[1] = CH_LF;
      n_new  = GRP_CNT_W'(2) + GRP_CNT_W'(b_v);
    end else if (td_tab) begin
      chr[0] = CH_TAB;
      n_new  = GRP_CNT_W'(1) + GRP_CNT_W'(b_v);
    end else begin
      n_new  = GRP_CNT_W'(b_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= HIST_RESET;
      s1_v_r    <= 1'b0;
      tobj_r    <= 1'b0;
      str_r     <= 1'b0;
      esc_r     <= 1'b0;
      grp_cnt_r <= '0;
      spc_thr_r <= SPACE_GAP_RST;
      tab_thr_r <= TAB_GAP_RST;
    end else begin
      if (in_acc) begin
        if (in_tlast) begin
          hist_r <= HIST_RESET;
        end else begin
          hist_r <= {in_tdata, hist_r[D-1:1]};
        end
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        tobj_r <= tobj_nxt;
        str_r  <= str_nxt;
        esc_r  <= esc_nxt;
      end
      if (s1_adv && (n_new != '0)) begin
        grp_cnt_r <= n_new;
      end else if (pop) begin
        grp_cnt_r <= grp_cnt_r - GRP_CNT_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPACE_GAP: spc_thr_r <= cfg_wdata;
          CFG_TAB_GAP:   tab_thr_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r   <= in_tdata;
      s1_last_r   <= in_tlast;
      s1_td_r     <= td_hit;
      s1_et_r     <= et_hit;
      s1_bt_r     <= bt_hit;
      s1_num_td_r <= num_td;
      s1_num_pa_r <= num_pa;
    end
    if (s1_adv && (n_new != '0)) begin
      grp_chr_r <= chr;
    end else if (pop) begin
      grp_chr_r[0] <= grp_chr_r[1];
      grp_chr_r[1] <= grp_chr_r[2];
    end
  end

  `PTE_ASSERT_IMPL(a_esc_in_string, esc_r, str_r, "escape pending outside a string")
  `PTE_ASSERT_IMPL(a_string_in_text, str_r, tobj_r, "string open outside a text object")
  `PTE_ASSERT_NEXT(a_hist_clear, in_acc && in_tlast, hist_r == HIST_RESET, "history not cleared")

endmodule
